>>> src/sorted_list_insert_delete_defines.svh
// assertion macros for the sorted list block
// no dependencies; included by files that carry assertions
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication, checked on every clk edge outside reset
`define SLI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clk edge outside reset
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sli_pkg.sv
// shared types and constants for the sorted list block
// no dependencies; used by sli_cell and sorted_list_insert_delete
package sli_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int VALUE_W        = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } sli_opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_EMPTY     = 2'd3
    } sli_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_STREAM
    } sli_state_t;

    // what every cell of the row does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } sli_cell_op_t;

    typedef struct packed {
        sli_cell_op_t               op;
        logic signed [VALUE_W-1:0]  operand;
    } sli_cell_ctrl_t;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [VALUE_W-1:0]  operand_value;
    } sli_req_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [VALUE_W-1:0]  out_value;
        logic                       last;
    } sli_rsp_t;

endpackage

>>> src/sli_cell.sv
// one storage cell of the sorted row: compare against the operand and shift
// depends on sli_pkg
module sli_cell (
    input  logic                                clk,
    input  sli_pkg::sli_cell_ctrl_t             ctrl,
    input  logic                                occupied,
    input  logic                                is_tail,
    input  logic                                left_lt,
    input  logic signed [sli_pkg::VALUE_W-1:0]  left_value,
    input  logic signed [sli_pkg::VALUE_W-1:0]  right_value,
    input  logic signed [sli_pkg::VALUE_W-1:0]  head_value,
    output logic                                lt,
    output logic                                eq,
    output logic signed [sli_pkg::VALUE_W-1:0]  value
);

    logic signed [sli_pkg::VALUE_W-1:0] value_reg;
    logic signed [sli_pkg::VALUE_W-1:0] value_next;

    assign lt    = occupied && ($signed(value_reg) < $signed(ctrl.operand));
    assign eq    = occupied && (value_reg == ctrl.operand);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            sli_pkg::CELL_INSERT:
            begin
                // first cell not below the operand takes it, later ones move right
                if (!lt)
                begin
                    value_next = left_lt ? ctrl.operand : left_value;
                end
            end
            sli_pkg::CELL_DELETE:
            begin
                if (!lt)
                begin
                    value_next = right_value;
                end
            end
            sli_pkg::CELL_ROTATE:
            begin
                value_next = is_tail ? head_value : right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

>>> src/sorted_list_insert_delete.sv
// top level of the sorted list block: control sequencer and the row of cells
// depends on sli_pkg, sli_cell and sorted_list_insert_delete_defines.svh
`include "sorted_list_insert_delete_defines.svh"

// Sorted list of up to LIST_DEPTH signed 32-bit values kept in ascending order
// in a row of compare-and-shift cells. A request transaction on req carries an
// opcode and an operand: insert places the operand ahead of the first stored
// value that is not smaller (duplicates allowed), delete removes the first
// stored value equal to the operand, read-out streams every stored value in
// ascending order with last set on the final one. Insert and delete answer
// with one response transaction on rsp (status ok, full, not found or empty,
// out_value zero). Opcode 3 is dropped with no response. One request is in
// flight at a time. Insert and delete are accepted, then every cell compares
// in parallel and the row shifts by one place. A read-out streams from the
// head cell into the single response register as the row rotates left one
// place per cycle while the response register is not stalled. A stalled
// response register holds the row until it drains; the next request may be
// accepted while the last response still waits.
module sorted_list_insert_delete #(
    parameter int LIST_DEPTH = sli_pkg::LIST_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  sli_pkg::sli_req_t  req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sli_pkg::sli_rsp_t  rsp
);

    // counter wide enough to hold the depth itself
    localparam int CW = $clog2(LIST_DEPTH + 1);

    sli_pkg::sli_state_t                state_reg;
    sli_pkg::sli_state_t                state_next;
    logic [1:0]                         op_reg;
    logic signed [sli_pkg::VALUE_W-1:0] operand_reg;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic [CW-1:0]                      rem_reg;
    logic [CW-1:0]                      rem_next;
    logic                               rsp_valid_reg;
    logic                               rsp_valid_next;
    sli_pkg::sli_rsp_t                  rsp_reg;
    sli_pkg::sli_rsp_t                  rsp_next;

    sli_pkg::sli_cell_ctrl_t            cell_ctrl;
    logic [LIST_DEPTH-1:0]              lt_vec;
    logic [LIST_DEPTH-1:0]              eq_vec;
    logic [LIST_DEPTH-1:0]              occ_vec;
    logic [LIST_DEPTH-1:0]              tail_vec;
    logic signed [sli_pkg::VALUE_W-1:0] value_vec [LIST_DEPTH];

    logic                               slot_free;
    logic                               list_full;
    logic                               list_empty;
    logic                               found;

    // response register can take a new transaction this cycle
    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign list_full  = (count_reg == CW'(LIST_DEPTH));
    assign list_empty = (count_reg == '0);
    // entries are sorted, so any match means the first value not below it matches
    assign found      = |eq_vec;

    assign req_stall  = (state_reg != sli_pkg::S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // row of cells: each cell sees its neighbors and the head for wraparound
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic                               left_lt;
        logic signed [sli_pkg::VALUE_W-1:0] left_value;
        logic signed [sli_pkg::VALUE_W-1:0] right_value;

        assign occ_vec[i]  = (CW'(i) < count_reg);
        assign tail_vec[i] = (CW'(i + 1) == count_reg);

        if (i == 0)
        begin : g_first
            assign left_lt    = 1'b1;
            assign left_value = cell_ctrl.operand;
        end
        else
        begin : g_inner
            assign left_lt    = lt_vec[i-1];
            assign left_value = value_vec[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_end
            assign right_value = value_vec[i];
        end
        else
        begin : g_mid
            assign right_value = value_vec[i+1];
        end

        sli_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .occupied    (occ_vec[i]),
            .is_tail     (tail_vec[i]),
            .left_lt     (left_lt),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (value_vec[0]),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i]),
            .value       (value_vec[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sli_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sli_pkg::S_EXEC;
                end
            end
            sli_pkg::S_EXEC:
            begin
                if (op_reg == sli_pkg::OP_READ)
                begin
                    if (slot_free)
                    begin
                        if (count_reg > CW'(1))
                        begin
                            state_next = sli_pkg::S_STREAM;
                        end
                        else
                        begin
                            state_next = sli_pkg::S_IDLE;
                        end
                    end
                end
                else if (op_reg == sli_pkg::OP_INSERT || op_reg == sli_pkg::OP_DELETE)
                begin
                    if (slot_free)
                    begin
                        state_next = sli_pkg::S_IDLE;
                    end
                end
                else
                begin
                    // unused opcode, nothing to answer
                    state_next = sli_pkg::S_IDLE;
                end
            end
            sli_pkg::S_STREAM:
            begin
                if (slot_free && rem_reg == CW'(1))
                begin
                    state_next = sli_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sli_pkg::S_IDLE;
            end
        endcase
    end

    // datapath control and response
    always_comb
    begin
        cell_ctrl.op      = sli_pkg::CELL_HOLD;
        cell_ctrl.operand = operand_reg;
        count_next        = count_reg;
        rem_next          = rem_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        rsp_next          = rsp_reg;
        case (state_reg)
            sli_pkg::S_EXEC:
            begin
                if (slot_free)
                begin
                    rsp_next.out_value = '0;
                    rsp_next.last      = 1'b1;
                    case (op_reg)
                        sli_pkg::OP_INSERT:
                        begin
                            rsp_valid_next = 1'b1;
                            if (list_full)
                            begin
                                rsp_next.status = sli_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                rsp_next.status = sli_pkg::STATUS_OK;
                                cell_ctrl.op    = sli_pkg::CELL_INSERT;
                                count_next      = count_reg + CW'(1);
                            end
                        end
                        sli_pkg::OP_DELETE:
                        begin
                            rsp_valid_next = 1'b1;
                            if (list_empty)
                            begin
                                rsp_next.status = sli_pkg::STATUS_EMPTY;
                            end
                            else if (!found)
                            begin
                                rsp_next.status = sli_pkg::STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                rsp_next.status = sli_pkg::STATUS_OK;
                                cell_ctrl.op    = sli_pkg::CELL_DELETE;
                                count_next      = count_reg - CW'(1);
                            end
                        end
                        sli_pkg::OP_READ:
                        begin
                            rsp_valid_next = 1'b1;
                            if (list_empty)
                            begin
                                rsp_next.status = sli_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // first value leaves from the head, row turns one place
                                rsp_next.status    = sli_pkg::STATUS_OK;
                                rsp_next.out_value = value_vec[0];
                                rsp_next.last      = (count_reg == CW'(1));
                                cell_ctrl.op       = sli_pkg::CELL_ROTATE;
                                rem_next           = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = rsp_valid_reg && rsp_stall;
                        end
                    endcase
                end
            end
            sli_pkg::S_STREAM:
            begin
                if (slot_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = sli_pkg::STATUS_OK;
                    rsp_next.out_value = value_vec[0];
                    rsp_next.last      = (rem_reg == CW'(1));
                    cell_ctrl.op       = sli_pkg::CELL_ROTATE;
                    rem_next           = rem_reg - CW'(1);
                end
            end
            default:
            begin
                cell_ctrl.op = sli_pkg::CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sli_pkg::S_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == sli_pkg::S_IDLE && req_valid)
        begin
            op_reg      <= req.opcode;
            operand_reg <= req.operand_value;
        end
        rsp_reg <= rsp_next;
    end

    // the fill count never passes the row length
    `SLI_ASSERT_IMPL(a_count_range, 1'b1, count_reg <= CW'(LIST_DEPTH),
        "count exceeds depth")

    // a committed insert grows the list by exactly one
    `SLI_ASSERT_NEXT(a_insert_grows,
        state_reg == sli_pkg::S_EXEC && slot_free
            && op_reg == sli_pkg::OP_INSERT && !list_full,
        count_reg == $past(count_reg) + CW'(1),
        "insert did not grow list")

    // streaming only happens over a non-empty list with values left to send
    `SLI_ASSERT_IMPL(a_stream_nonempty, state_reg == sli_pkg::S_STREAM,
        count_reg != '0 && rem_reg != '0 && rem_reg < count_reg,
        "stream state with bad count")

    // the final streamed value is marked last and frees the block
    `SLI_ASSERT_NEXT(a_stream_last,
        state_reg == sli_pkg::S_STREAM && slot_free && rem_reg == CW'(1),
        state_reg == sli_pkg::S_IDLE && rsp_valid_reg && rsp_reg.last,
        "stream end not marked last")

endmodule
